// ===== sv/dwmd_pkg.sv =====
// ----------------------------------------------------------------------------
// dwmd_pkg: shared constants for the distinct window marker detector
// Field widths of the stream and configuration ports, parameter defaults and the window_length reset value.
// ----------------------------------------------------------------------------
package dwmd_pkg;

  localparam int LETTER_W = 5;   // letter field, a=0 through z=25
  localparam int IN_W     = 8;   // letter padded to a whole byte
  localparam int CFG_W    = 5;   // window_length register

  localparam int DEF_MAX_WINDOW    = 16;
  localparam int DEF_ALPHABET_SIZE = 26;
  localparam int DEF_POSITION_BITS = 24;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = CFG_W'(4);

endpackage

// ===== sv/distinct_window_marker_detector.sv =====
// ----------------------------------------------------------------------------
// distinct_window_marker_detector
// Finds the first letter at which the last window_length letters are all
// distinct, and reports the latched flag and 1-based position per request.
// ----------------------------------------------------------------------------
// a result is registered in the output register when its request is taken, or in the skid entry while stalled
// throughput: one request per cycle while the skid entry is empty; set by the single count/ring update step
// an output register plus one skid entry keep in_tready off out_tready
// reset: synchronous, active low; letter counts, window pointer, fill level,
//   position counter and found latch clear at once, no clearing pass
module distinct_window_marker_detector #(
  parameter int MAX_WINDOW    = dwmd_pkg::DEF_MAX_WINDOW,
  parameter int ALPHABET_SIZE = dwmd_pkg::DEF_ALPHABET_SIZE,
  parameter int POSITION_BITS = dwmd_pkg::DEF_POSITION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write: window_length
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dwmd_pkg::CFG_W-1:0]    cfg_data,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dwmd_pkg::IN_W-1:0]     in_tdata,   // [4:0] letter, rest zero
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [((POSITION_BITS+8)/8)*8-1:0] out_tdata  // [0] marker_found,
                                                       // [POSITION_BITS:1]
                                                       // marker_position
);
  import dwmd_pkg::*;

  localparam int OUT_W = ((POSITION_BITS + 8) / 8) * 8;
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (WIN_W > CFG_W) ? WIN_W : CFG_W;
  localparam int ALPH_W = $clog2(ALPHABET_SIZE + 1);
  localparam int IDX_W = (ALPH_W > LETTER_W) ? ALPH_W : LETTER_W;

  function automatic logic [WIN_W-1:0] eff_win(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) begin
      return WIN_W'(1);
    end else if (w > CMP_W'(MAX_WINDOW)) begin
      return WIN_W'(MAX_WINDOW);
    end else begin
      return WIN_W'(w);
    end
  endfunction

  // window state
  logic [WIN_W-1:0]         win_r;
  logic [PTR_W-1:0]         ptr_r, ptr_nxt;
  logic [WIN_W-1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]         counts_r [ALPHABET_SIZE];
  logic [CNT_W-1:0]         counts_nxt [ALPHABET_SIZE];
  logic [LETTER_W-1:0]      ring_r [MAX_WINDOW];
  logic [POSITION_BITS-1:0] rcvd_r, rcvd_nxt;
  logic                     found_r, found_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  // output register and skid entry
  logic                     out_v_r, sk_v_r;
  logic [OUT_W-1:0]         out_d_r, sk_d_r;

  logic                     in_fire, out_fire, cfg_fire;
  logic [LETTER_W-1:0]      letter;
  logic                     letter_ok;
  logic                     full, full_nxt;
  logic [LETTER_W-1:0]      old_letter;
  logic [ALPHABET_SIZE-1:0] dup;
  logic                     distinct;
  logic [OUT_W-1:0]         result;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_tready = ~sk_v_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_v_r & out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  assign letter     = in_tdata[LETTER_W-1:0];
  assign letter_ok  = IDX_W'(letter) < IDX_W'(ALPHABET_SIZE);
  assign full       = fill_r >= win_r;
  assign old_letter = ring_r[ptr_r];

  // one lane per letter: drop the letter leaving the window, add the new one
  always_comb begin
    logic hit_new;
    logic hit_old;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      hit_new = letter_ok && (IDX_W'(letter) == IDX_W'(i));
      hit_old = letter_ok && full && (IDX_W'(old_letter) == IDX_W'(i)) &&
                (counts_r[i] != '0);
      counts_nxt[i] = counts_r[i] + CNT_W'(hit_new) - CNT_W'(hit_old);
      dup[i]        = counts_nxt[i] > CNT_W'(1);
    end
  end

  always_comb begin
    fill_nxt  = full ? fill_r : fill_r + WIN_W'(1);
    full_nxt  = fill_nxt >= win_r;
    ptr_nxt   = ((WIN_W'(ptr_r) + WIN_W'(1)) >= win_r) ? '0 : ptr_r + PTR_W'(1);
    rcvd_nxt  = (rcvd_r == '1) ? rcvd_r : rcvd_r + POSITION_BITS'(1);
    distinct  = full_nxt & ~(|dup);
    found_nxt = found_r;
    pos_nxt   = pos_r;
    if (letter_ok && !found_r && distinct) begin
      found_nxt = 1'b1;
      pos_nxt   = rcvd_nxt;
    end
    result = OUT_W'({pos_nxt, found_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= eff_win(WINDOW_LENGTH_RST);
      ptr_r   <= '0;
      fill_r  <= '0;
      rcvd_r  <= '0;
      found_r <= 1'b0;
      pos_r   <= '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        counts_r[i] <= '0;
      end
    end else if (cfg_fire) begin
      // new window length restarts the window, keeps the latched marker
      win_r  <= eff_win(cfg_data);
      ptr_r  <= '0;
      fill_r <= '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        counts_r[i] <= '0;
      end
    end else if (in_fire && letter_ok) begin
      ptr_r   <= ptr_nxt;
      fill_r  <= fill_nxt;
      rcvd_r  <= rcvd_nxt;
      found_r <= found_nxt;
      pos_r   <= pos_nxt;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        counts_r[i] <= counts_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && letter_ok && !cfg_fire) begin
      ring_r[ptr_r] <= letter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (out_fire) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_v_r || out_fire) begin
        out_v_r <= 1'b1;
      end else begin
        sk_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (out_fire) begin
        out_d_r <= sk_d_r;
      end
    end else if (in_fire) begin
      if (!out_v_r || out_fire) begin
        out_d_r <= result;
      end else begin
        sk_d_r <= result;
      end
    end
  end

endmodule

// ===== sv/dwmd_checker.sv =====
// ----------------------------------------------------------------------------
// dwmd_checker: port-level checks for the distinct window marker detector
// Watches the result stream and flow control; attached by bind.
// ----------------------------------------------------------------------------
module dwmd_checker #(
  parameter int POSITION_BITS = dwmd_pkg::DEF_POSITION_BITS
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [((POSITION_BITS+8)/8)*8-1:0]    out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the marker latches: a found result is never followed by a not-found one
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |=> !out_tvalid || out_tdata[0])
    else $error("marker_found dropped");

  // no position before the marker is found
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[POSITION_BITS:1] == '0)
    else $error("position set without marker");

  // found position is at least one letter
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[POSITION_BITS:1] != '0)
    else $error("marker found at position zero");

  // input only stalls while a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind distinct_window_marker_detector dwmd_checker #(
  .POSITION_BITS(POSITION_BITS)
) u_dwmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: distinct window marker detector testbench
// Streams letters through the detector under random source gaps and sink
// stalls, rewrites window_length between phases, and checks every result
// against an in-bench tracker of the window counts and the found latch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int MAX_WIN     = dwmd_pkg::DEF_MAX_WINDOW;
  localparam int ALPHA       = dwmd_pkg::DEF_ALPHABET_SIZE;
  localparam int POS_W       = dwmd_pkg::DEF_POSITION_BITS;
  localparam int OUT_W       = ((POS_W + 8) / 8) * 8;
  localparam int STALL_LIMIT = 500;
  localparam int CALM_TAIL   = 150;

  typedef enum logic {REQ_LETTER, REQ_WINDOW} req_kind_t;

  typedef struct {
    req_kind_t                      kind;
    logic [dwmd_pkg::LETTER_W-1:0]  value;
  } feed_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } marker_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [dwmd_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [dwmd_pkg::IN_W-1:0]   in_tdata = '0;   // [4:0] letter, rest zero
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [OUT_W-1:0]            out_tdata;       // [0] found, [POS_W:1] position

  distinct_window_marker_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // tracker state, mirrors the block
  logic [dwmd_pkg::LETTER_W-1:0] hist_ring [MAX_WIN];
  logic [4:0]                    hist_count [ALPHA];
  logic [4:0]                    hist_wptr;
  logic [4:0]                    hist_fill;
  logic [dwmd_pkg::CFG_W-1:0]    win_len;
  logic [POS_W-1:0]              letters_seen;
  logic                          marker_hit;
  logic [POS_W-1:0]              marker_pos;

  feed_t       feed_q [$];
  marker_t     marker_expect_q [$];
  marker_t     want;
  int unsigned letter_order [ALPHA];

  int  mismatches = 0;
  int  letters_sent = 0;
  int  results_checked = 0;
  int  window_writes = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  quiet_cycles = 0;
  logic drive_in, drive_cfg;

  function automatic int eff_window(input logic [dwmd_pkg::CFG_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_WIN) return MAX_WIN;
    return int'(len);
  endfunction

  function automatic void restart_window();
    foreach (hist_count[i]) hist_count[i] = '0;
    hist_wptr = '0;
    hist_fill = '0;
  endfunction

  function automatic void apply_window(input logic [dwmd_pkg::CFG_W-1:0] len);
    win_len = len;
    window_writes++;
    restart_window();
  endfunction

  function automatic void track_letter(input logic [dwmd_pkg::LETTER_W-1:0] letter);
    int  w;
    logic [dwmd_pkg::LETTER_W-1:0] old;
    logic dup;
    w = eff_window(win_len);
    if (letter < ALPHA) begin
      if (hist_wptr >= w) hist_wptr = '0;
      // once full, the slot about to be overwritten leaves the window
      if (hist_fill >= w) begin
        old = hist_ring[hist_wptr];
        if (old < ALPHA && hist_count[old] > 0) hist_count[old]--;
      end
      hist_ring[hist_wptr] = letter;
      hist_count[letter]++;
      hist_wptr = (hist_wptr + 5'd1 >= w) ? '0 : hist_wptr + 5'd1;
      if (hist_fill < w) hist_fill++;
      if (letters_seen != '1) letters_seen++;
      dup = 1'b0;
      foreach (hist_count[i]) if (hist_count[i] > 1) dup = 1'b1;
      if (!marker_hit && hist_fill >= w && !dup) begin
        marker_hit = 1'b1;
        marker_pos = letters_seen;
      end
    end
    marker_expect_q.push_back('{found: marker_hit, pos: marker_pos});
  endfunction

  // 0 means no idling; otherwise one chance in the returned number
  function automatic int idle_odds();
    if (feed_q.size() < CALM_TAIL) return 0;
    case ((letters_sent / 80) % 3)
      0: return 0;
      1: return 10;
      default: return 3;
    endcase
  endfunction

  function automatic void push_letter(input int unsigned v);
    feed_q.push_back('{kind: REQ_LETTER, value: v[dwmd_pkg::LETTER_W-1:0]});
  endfunction

  function automatic void push_window(input int unsigned v);
    feed_q.push_back('{kind: REQ_WINDOW, value: v[dwmd_pkg::CFG_W-1:0]});
  endfunction

  function automatic void shuffle_order(input int n);
    int j;
    int unsigned t;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = letter_order[i];
      letter_order[i] = letter_order[j];
      letter_order[j] = t;
    end
  endfunction

  // letters drawn from a pool one short of the window: never a marker
  function automatic void add_near_miss_phase(input int unsigned len, input int count);
    int k, n;
    k = eff_window(len) - 1;
    push_window(len);
    shuffle_order(ALPHA);
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_letter($urandom_range(ALPHA, 31));
      end else if ($urandom_range(0, 2) == 0) begin
        shuffle_order(k);
        for (int i = 0; i < k; i++) push_letter(letter_order[i]);
        push_letter(letter_order[$urandom_range(0, k - 1)]);
        n += k + 1;
      end else begin
        push_letter(letter_order[$urandom_range(0, k - 1)]);
        n++;
      end
    end
  endfunction

  // some near-miss lead-in, a full run of distinct letters, then random letters
  function automatic void add_marker_phase(input int unsigned len, input int count);
    int w;
    w = eff_window(len);
    push_window(len);
    shuffle_order(ALPHA);
    if (w > 1)
      for (int i = 0; i < 6; i++) push_letter(letter_order[$urandom_range(0, w - 2)]);
    shuffle_order(ALPHA);
    for (int i = 0; i < w; i++) push_letter(letter_order[i]);
    for (int i = w + 6; i < count; i++) push_letter($urandom_range(0, 31));
  endfunction

  function automatic void add_open_phase(input int unsigned len, input int count);
    push_window(len);
    for (int i = 0; i < count; i++) push_letter($urandom_range(0, 31));
  endfunction

  // source side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_window(cfg_data);
      if (in_tvalid && in_tready) begin
        track_letter(in_tdata[dwmd_pkg::LETTER_W-1:0]);
        letters_sent++;
      end
      if (!(in_tvalid && !in_tready) && !(cfg_valid && !cfg_ready)) begin
        drive_in = 1'b0;
        drive_cfg = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (feed_q.size() > 0) begin
          if (feed_q[0].kind == REQ_WINDOW) begin
            // register writes only once every result is back
            if (marker_expect_q.size() == 0) begin
              drive_cfg = 1'b1;
              cfg_data <= feed_q[0].value;
              void'(feed_q.pop_front());
            end
          end else if (idle_odds() != 0 && $urandom_range(1, idle_odds()) == 1) begin
            send_gap = $urandom_range(0, 11);
          end else begin
            drive_in = 1'b1;
            in_tdata <= dwmd_pkg::IN_W'(feed_q[0].value);
            void'(feed_q.pop_front());
          end
        end
        in_tvalid <= drive_in;
        cfg_valid <= drive_cfg;
      end
    end
  end

  // sink side and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (marker_expect_q.size() == 0) begin
          $display("%0t: unexpected result, found=%0b position=%0d", $time,
                   out_tdata[0], out_tdata[POS_W:1]);
          mismatches++;
        end else begin
          want = marker_expect_q.pop_front();
          if (out_tdata[0] !== want.found) begin
            $display("%0t: found flag expected %0b actual %0b", $time, want.found,
                     out_tdata[0]);
            mismatches++;
          end
          if (out_tdata[POS_W:1] !== want.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, want.pos,
                     out_tdata[POS_W:1]);
            mismatches++;
          end
          if (out_tdata[OUT_W-1:POS_W+1] !== '0) begin
            $display("%0t: padding expected 0 actual %h", $time,
                     out_tdata[OUT_W-1:POS_W+1]);
            mismatches++;
          end
        end
      end
      if (recv_stall > 0) begin
        out_tready <= 1'b0;
        recv_stall--;
      end else if (idle_odds() != 0 && $urandom_range(1, idle_odds()) == 1) begin
        out_tready <= 1'b0;
        recv_stall = $urandom_range(0, 11);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d requests still queued", $time,
               quiet_cycles, feed_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (hist_ring[i]) hist_ring[i] = '0;
    foreach (letter_order[i]) letter_order[i] = i;
    restart_window();
    win_len = dwmd_pkg::WINDOW_LENGTH_RST;
    letters_seen = '0;
    marker_hit = 1'b0;
    marker_pos = '0;

    // directed: reset window of four, repeats only, out-of-alphabet letters,
    // restart on rewrite of the same length
    for (int i = 0; i < 4; i++) push_letter(0);
    push_letter(31);
    push_letter(ALPHA);
    push_letter(25); push_letter(24); push_letter(25); push_letter(24);
    push_window(4);
    push_letter(1); push_letter(2); push_letter(3);
    push_window(4);
    push_letter(3); push_letter(3);

    // no marker yet: lengths above the maximum clamp, down to two
    add_near_miss_phase(31, 60);
    add_near_miss_phase(17, 60);
    add_near_miss_phase(16, 60);
    add_near_miss_phase(15, 60);
    add_near_miss_phase(12, 60);
    add_near_miss_phase(9, 60);
    add_near_miss_phase(7, 60);
    add_near_miss_phase(5, 60);
    add_near_miss_phase(3, 60);
    add_near_miss_phase(2, 60);
    add_marker_phase($urandom_range(1, 16), 60);
    // latched from here on; zero length acts as one
    add_open_phase(0, 70);
    add_open_phase(1, 70);
    add_open_phase(16, 70);
    add_open_phase(31, 70);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (!(feed_q.size() == 0 && !in_tvalid && !cfg_valid &&
             marker_expect_q.size() == 0))
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d letters over %0d window writes, checked %0d results",
             letters_sent, window_writes, results_checked);
    $display("marker latched=%0b at letter %0d", marker_hit, marker_pos);
    if (mismatches == 0 && marker_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
